FILE: rtl/htq_pkg.sv
`timescale 1ns / 1ps
// shared constants and codes for the heightmap triangle height query block
// no dependencies

package htq_pkg;

  // map geometry
  localparam int GridMax  = 256;
  localparam int FracBits = 8;
  localparam int AddrW    = $clog2(GridMax * GridMax);
  localparam int IdxW     = $clog2(GridMax);

  // field widths
  localparam int DimW     = 9;
  localparam int ScaleW   = 16;
  localparam int ByteW    = 8;
  localparam int PosW     = 17;
  localparam int HeightW  = 16;
  localparam int CellW    = AddrW + 1;

  // arithmetic widths
  localparam int WeightW  = FracBits + 1;
  localparam int SumW     = ByteW + FracBits;
  localparam int ProdW    = SumW + ScaleW;
  localparam int QuotInW  = ProdW - FracBits;
  localparam int QuotW    = QuotInW - 7;

  // raw byte full scale and the shift of its reciprocal, 2^24 / 255 rounded down
  localparam int RawMax   = 255;
  localparam int RecipSh  = 24;

  // stream bus widths
  localparam int InDataW  = ((ByteW + 2 * PosW + 7) / 8) * 8;
  localparam int OutDataW = ((HeightW + 7) / 8) * 8;

  // apb
  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;

  typedef enum logic {
    RegGridDim     = 1'b0,
    RegHeightScale = 1'b1
  } reg_idx_e;

  typedef enum logic {
    KindLoad  = 1'b0,
    KindQuery = 1'b1
  } kind_e;

endpackage

FILE: rtl/htq_ram.sv
`timescale 1ns / 1ps
// generic single-write, single-read synchronous ram with registered read data
// no dependencies

module htq_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/heightmap_triangle_height_query.sv
`timescale 1ns / 1ps
// heightmap triangle height query: load stream, query pipeline, apb registers
// depends on htq_pkg and htq_ram

// The block takes one item per clock, loads and queries mixed freely, and
// presents a query's result on the output after the weight, sum, product,
// quotient and output registers; loads give no result. A stall on the
// output freezes the whole pipeline, so the input side stalls with it. The map
// lives in three copies of a 64K-byte memory that every load writes together;
// each copy is read at one triangle corner per cycle, which is what lets a
// query enter every cycle. Entries need no clearing after reset: the map must
// be loaded before it is queried. Loads fill in raster order, x fastest, and
// wrap after grid_dimension (capped at 256) squared bytes. Register map:
// 0x0 grid_dimension, 0x4 height_scale (unsigned Q8.8 height of raw byte 255).

module heightmap_triangle_height_query (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // stream in
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [7:0] height_byte, [24:8] pos_x, [41:25] pos_z, rest zero
  input  logic [htq_pkg::InDataW-1:0]    s_axis_tdata,
  // [0] kind
  input  logic                           s_axis_tuser,
  // stream out
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [15:0] height_out
  output logic [htq_pkg::OutDataW-1:0]   m_axis_tdata,
  // [0] in_grid
  output logic                           m_axis_tuser,
  // apb
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [htq_pkg::ApbAddrW-1:0]   paddr,
  input  logic [htq_pkg::ApbDataW-1:0]   pwdata,
  output logic [htq_pkg::ApbDataW-1:0]   prdata,
  output logic                           pready
);

  localparam int AddrW   = htq_pkg::AddrW;
  localparam int CellW   = htq_pkg::CellW;
  localparam int DimW    = htq_pkg::DimW;
  localparam int IdxW    = htq_pkg::IdxW;
  localparam int FracB   = htq_pkg::FracBits;
  localparam int ByteW   = htq_pkg::ByteW;
  localparam int PosW    = htq_pkg::PosW;
  localparam int WeightW = htq_pkg::WeightW;
  localparam int SumW    = htq_pkg::SumW;
  localparam int ProdW   = htq_pkg::ProdW;
  localparam int QinW    = htq_pkg::QuotInW;
  localparam int QuotW   = htq_pkg::QuotW;
  localparam int RecipW  = QinW + htq_pkg::RecipSh - 7;

  // ---------------------------------------------------------------- registers
  logic [DimW-1:0]           dim_q;
  logic [htq_pkg::ScaleW-1:0] scale_q;
  logic                      cfg_wr;
  htq_pkg::reg_idx_e         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = htq_pkg::reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q   <= DimW'(256);
      scale_q <= htq_pkg::ScaleW'(256);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        htq_pkg::RegGridDim:     dim_q   <= pwdata[DimW-1:0];
        htq_pkg::RegHeightScale: scale_q <= pwdata[htq_pkg::ScaleW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      htq_pkg::RegGridDim:
        prdata = {{(htq_pkg::ApbDataW-DimW){1'b0}}, dim_q};
      htq_pkg::RegHeightScale:
        prdata = {{(htq_pkg::ApbDataW-htq_pkg::ScaleW){1'b0}}, scale_q};
      default: prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- handshake
  logic out_vld_q;
  logic adv;
  logic acc;
  logic is_load;
  logic is_query;

  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign acc           = s_axis_tvalid && adv;
  assign is_load       = acc && (htq_pkg::kind_e'(s_axis_tuser) == htq_pkg::KindLoad);
  assign is_query      = acc && (htq_pkg::kind_e'(s_axis_tuser) == htq_pkg::KindQuery);

  logic [DimW-1:0] dim_use;
  assign dim_use = (dim_q > DimW'(htq_pkg::GridMax)) ? DimW'(htq_pkg::GridMax) : dim_q;

  // ---------------------------------------------------------------- load path
  logic [CellW-1:0] cells;
  logic [AddrW-1:0] lp_q;
  logic [AddrW-1:0] lp_d;
  logic [AddrW-1:0] lp_eff;
  logic [CellW-1:0] lp_inc;
  logic             mem_we;

  assign cells  = CellW'(dim_use) * CellW'(dim_use);
  // pointer past the map after the dimension was lowered starts over at zero
  assign lp_eff = ({1'b0, lp_q} >= cells) ? '0 : lp_q;
  assign lp_inc = {1'b0, lp_eff} + CellW'(1);
  assign lp_d   = (lp_inc >= cells) ? '0 : lp_inc[AddrW-1:0];
  assign mem_we = is_load && (cells != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_q <= '0;
    end else if (mem_we) begin
      lp_q <= lp_d;
    end
  end

  // ---------------------------------------------------------------- query decode
  logic signed [PosW-1:0] pos_x;
  logic signed [PosW-1:0] pos_z;
  logic [IdxW-1:0]        xi;
  logic [IdxW-1:0]        zi;
  logic [FracB-1:0]       u;
  logic [FracB-1:0]       v;
  logic                   in_rng;
  logic                   upper;
  logic [CellW-1:0]       bl_full;
  logic [CellW-1:0]       tl_full;
  logic [AddrW-1:0]       addr_bl;
  logic [AddrW-1:0]       addr_mid;
  logic [AddrW-1:0]       addr_tr;
  logic [FracB-1:0]       wa;
  logic [FracB-1:0]       wb;
  logic [WeightW-1:0]     wc;

  assign pos_x = s_axis_tdata[ByteW +: PosW];
  assign pos_z = s_axis_tdata[ByteW+PosW +: PosW];
  assign xi    = pos_x[FracB +: IdxW];
  assign zi    = pos_z[FracB +: IdxW];
  assign u     = pos_x[FracB-1:0];
  assign v     = pos_z[FracB-1:0];

  // negative positions floor below zero and fall outside
  assign in_rng = !pos_x[PosW-1] && !pos_z[PosW-1]
               && (pos_x[PosW-2:FracB] == (PosW-1-FracB)'(xi))
               && (pos_z[PosW-2:FracB] == (PosW-1-FracB)'(zi))
               && ((DimW'(xi) + DimW'(1)) < dim_use)
               && ((DimW'(zi) + DimW'(1)) < dim_use);

  assign upper   = (u > v);
  assign bl_full = CellW'(xi) + CellW'(zi) * CellW'(dim_use);
  assign tl_full = bl_full + CellW'(dim_use);
  assign addr_bl  = bl_full[AddrW-1:0];
  assign addr_mid = upper ? AddrW'(bl_full + CellW'(1)) : tl_full[AddrW-1:0];
  assign addr_tr  = AddrW'(tl_full + CellW'(1));

  assign wa = upper ? (u - v) : (v - u);
  assign wb = upper ? v : u;
  assign wc = upper ? (WeightW'(1 << FracB) - WeightW'(u))
                    : (WeightW'(1 << FracB) - WeightW'(v));

  // ---------------------------------------------------------------- map copies
  logic [ByteW-1:0] d_bl;
  logic [ByteW-1:0] d_mid;
  logic [ByteW-1:0] d_tr;

  htq_ram #(.Width(ByteW), .Depth(1 << AddrW)) u_ram_bl (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (lp_eff),
    .wdata_i (s_axis_tdata[ByteW-1:0]),
    .re_i    (adv),
    .raddr_i (addr_bl),
    .rdata_o (d_bl)
  );

  htq_ram #(.Width(ByteW), .Depth(1 << AddrW)) u_ram_mid (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (lp_eff),
    .wdata_i (s_axis_tdata[ByteW-1:0]),
    .re_i    (adv),
    .raddr_i (addr_mid),
    .rdata_o (d_mid)
  );

  htq_ram #(.Width(ByteW), .Depth(1 << AddrW)) u_ram_tr (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (lp_eff),
    .wdata_i (s_axis_tdata[ByteW-1:0]),
    .re_i    (adv),
    .raddr_i (addr_tr),
    .rdata_o (d_tr)
  );

  // ---------------------------------------------------------------- pipeline
  logic                vld1_q, vld2_q, vld3_q, vld4_q;
  logic                rng1_q, rng2_q, rng3_q, rng4_q;
  logic [FracB-1:0]    wa1_q, wb1_q;
  logic [WeightW-1:0]  wc1_q;
  logic [SumW-1:0]     sum2_q;
  logic [ProdW-1:0]    prod3_q;
  logic [QinW-1:0]     x4_q;
  logic [QuotW-1:0]    qe4_q;
  logic [htq_pkg::HeightW-1:0] h_q;
  logic                in_q;

  logic [SumW+1:0]     sum_full;
  logic [QinW-1:0]     x3;
  logic [RecipW-1:0]   recip;
  logic [QuotW-1:0]    qe3;
  logic [QinW:0]       rem4;
  logic [QuotW-1:0]    q4;

  // weights sum to one in fixed point, so the sum fits SumW bits
  assign sum_full = (SumW+2)'(d_mid) * (SumW+2)'(wa1_q)
                  + (SumW+2)'(d_tr)  * (SumW+2)'(wb1_q)
                  + (SumW+2)'(d_bl)  * (SumW+2)'(wc1_q);

  // floor(x/255) as x*(2^16+2^8+1)>>24, low by at most one
  assign x3    = prod3_q[ProdW-1:FracB];
  assign recip = (RecipW'(x3) << 16) + (RecipW'(x3) << 8) + RecipW'(x3);
  assign qe3   = recip[htq_pkg::RecipSh +: QuotW];

  assign rem4 = (QinW+1)'(x4_q) - (((QinW+1)'(qe4_q) << 8) - (QinW+1)'(qe4_q));
  assign q4   = (rem4 >= (QinW+1)'(htq_pkg::RawMax)) ? (qe4_q + QuotW'(1)) : qe4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q    <= 1'b0;
      vld2_q    <= 1'b0;
      vld3_q    <= 1'b0;
      vld4_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld1_q    <= is_query;
      vld2_q    <= vld1_q;
      vld3_q    <= vld2_q;
      vld4_q    <= vld3_q;
      out_vld_q <= vld4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rng1_q  <= in_rng;
      wa1_q   <= wa;
      wb1_q   <= wb;
      wc1_q   <= wc;
      rng2_q  <= rng1_q;
      sum2_q  <= sum_full[SumW-1:0];
      rng3_q  <= rng2_q;
      prod3_q <= ProdW'(sum2_q) * ProdW'(scale_q);
      rng4_q  <= rng3_q;
      x4_q    <= x3;
      qe4_q   <= qe3;
      in_q    <= rng4_q;
      h_q     <= rng4_q ? q4[htq_pkg::HeightW-1:0] : '0;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = htq_pkg::OutDataW'(h_q);
  assign m_axis_tuser  = in_q;

endmodule

FILE: rtl/htq_checker.sv
`timescale 1ns / 1ps
// port-level checks for the heightmap triangle height query block
// depends on htq_pkg; bound to heightmap_triangle_height_query below

module htq_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [htq_pkg::OutDataW-1:0]   m_axis_tdata,
  input logic                           m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // an empty output register never holds back the input side
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with output empty");

  // outside the grid the height reads zero
  a_out_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("nonzero height outside grid");

endmodule

bind heightmap_triangle_height_query htq_checker u_htq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
